// ===== rtl/asm_token_classifier_core_macros.svh =====
// ----------------------------------------------------------------------------
// asm_token_classifier_core_macros.svh
// Assertion helper macros for the token classifier.
// ----------------------------------------------------------------------------
`ifndef ASM_TOKEN_CLASSIFIER_CORE_MACROS_SVH
`define ASM_TOKEN_CLASSIFIER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ATC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ATC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ATC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/atc_pkg.sv =====
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types, character constants and character tests of the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package atc_pkg;

  localparam int CHAR_W = 8;
  localparam int CLS_W  = 4;

  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;
  localparam logic [CHAR_W-1:0] CH_AT    = 8'h40; // '@'
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A; // ':'
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E; // '.'
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23; // '#'
  localparam logic [CHAR_W-1:0] CH_DOLLAR= 8'h24; // '$'
  localparam logic [CHAR_W-1:0] CH_R     = 8'h72; // 'r'
  localparam logic [CHAR_W-1:0] CH_P     = 8'h70; // 'p'
  localparam logic [CHAR_W-1:0] CH_S     = 8'h73; // 's'
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63; // 'c'
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78; // 'x'
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C; // ','
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A; // newline
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22; // '"'

  typedef enum logic [CLS_W-1:0] {
    CLS_UNKNOWN   = 4'd0,
    CLS_LABELDEF  = 4'd1,
    CLS_DIRECTIVE = 4'd2,
    CLS_INSTR     = 4'd3,
    CLS_REG       = 4'd4,
    CLS_IMM       = 4'd5,
    CLS_ADDR      = 4'd6,
    CLS_LABELREF  = 4'd7,
    CLS_COMMA     = 4'd8,
    CLS_STRING    = 4'd9,
    CLS_EOL       = 4'd10
  } cls_t;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_LATER  = 2'd3;

  // running per-token view
  typedef struct packed {
    logic [1:0]        pos;
    logic [CHAR_W-1:0] first_byte;
    logic [CHAR_W-1:0] second_byte;
    logic              third_is_x;
    logic              all_letters;
    logic              decimal_from_second;
    logic              hex_from_fourth;
  } tok_view_t;

  localparam tok_view_t TOK_INIT = '{
    pos:                 POS_FIRST,
    first_byte:          '0,
    second_byte:         '0,
    third_is_x:          1'b0,
    all_letters:         1'b1,
    decimal_from_second: 1'b1,
    hex_from_fourth:     1'b1
  };

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] l;
    l = c | CASE_BIT;
    return l inside {[8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] l;
    l = c | CASE_BIT;
    return l inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] l;
    l = c | CASE_BIT;
    return is_digit(c) || (l inside {[8'h61:8'h66]});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/atc_if.sv =====
// ----------------------------------------------------------------------------
// atc_if
// Valid/ready channels: character words in, class words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface atc_in_if;
  import atc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] token_char;
  logic              last_char;
  modport source (output valid, token_char, last_char, input ready);
  modport sink   (input valid, token_char, last_char, output ready);
endinterface

interface atc_out_if;
  import atc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CLS_W-1:0] token_class;
  modport source (output valid, token_class, input ready);
  modport sink   (input valid, token_class, output ready);
endinterface

`default_nettype wire

// ===== rtl/asm_token_classifier_core.sv =====
// ----------------------------------------------------------------------------
// asm_token_classifier_core
// Streams an assembler token one character per word and reports its class.
// ----------------------------------------------------------------------------
// Usage:
//  - in_chan carries one character per word (token_char) and last_char,
//    which closes the token. Words before the last produce nothing.
//  - out_chan carries one token_class word per token, sent after the last
//    character: 0 unknown, 1 labeldef ... 10 eol.
//  - Path: a last character accepted on in_chan shows its class on out_chan
//    once it has passed the input register and then the result register.
//  - Throughput: one character per cycle, sustained while out_chan is not held,
//    tokens back to back. The per-character work is a few flag updates plus the
//    class decode, all between the input register and the result register.
//  - Stall: while out_chan is held, non-last characters keep flowing in;
//    a last character waits in the input register, with in_chan.ready low,
//    until the result register frees up.
//  - Reset (rst_n low, synchronous): both registers empty, token state
//    back to the start of a token.
// ----------------------------------------------------------------------------
`default_nettype none
`include "asm_token_classifier_core_macros.svh"

module asm_token_classifier_core (
  input  wire        clk,
  input  wire        rst_n,
  atc_in_if.sink     in_chan,
  atc_out_if.source  out_chan
);
  import atc_pkg::*;

  // input register
  logic              in_valid_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;

  // result register
  logic              out_valid_r;
  cls_t              out_class_r;

  logic      adv;      // input register word consumed this cycle
  tok_view_t view;
  cls_t      cls;

  // a non-last char never needs result space
  assign adv = in_valid_r && (!in_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_char_r <= in_chan.token_char;
      in_last_r <= in_chan.last_char;
    end
  end

  atc_flags u_flags (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (adv),
    .char_i (in_char_r),
    .last_i (in_last_r),
    .view_o (view)
  );

  atc_classify u_classify (
    .view_i (view),
    .char_i (in_char_r),
    .cls_o  (cls)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_class_r <= cls;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.token_class = out_class_r;

  // closing a token always yields a result word next cycle
  `ATC_ASSERT_NXT(a_result_after_last, clk, rst_n, adv && in_last_r, out_valid_r, "no result after last char")
  // token state restarts after the closing character
  `ATC_ASSERT_NXT(a_pos_restart, clk, rst_n, adv && in_last_r, view.pos == POS_FIRST, "position not restarted")
  // a held input word is neither dropped nor overwritten
  `ATC_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid_r && !adv, in_valid_r && $stable(in_char_r), "input word lost")

endmodule

`default_nettype wire

// ===== rtl/atc_flags.sv =====
// ----------------------------------------------------------------------------
// atc_flags
// Per-token state: position, first bytes and running character flags.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_flags (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          step_i,   // char consumed this cycle
  input  wire [7:0]                    char_i,
  input  wire                          last_i,
  output atc_pkg::tok_view_t           view_o    // state including char_i
);
  import atc_pkg::*;

  tok_view_t state_r;
  tok_view_t view_nxt;
  tok_view_t state_nxt;

  always_comb begin
    view_nxt = state_r;
    if (state_r.pos == POS_FIRST)  view_nxt.first_byte  = char_i;
    if (state_r.pos == POS_SECOND) view_nxt.second_byte = char_i;
    if (state_r.pos == POS_THIRD)  view_nxt.third_is_x  = ((char_i | CASE_BIT) == CH_X);
    view_nxt.all_letters = state_r.all_letters && is_letter(char_i);
    view_nxt.decimal_from_second = state_r.decimal_from_second &&
                                   ((state_r.pos == POS_FIRST) || is_digit(char_i));
    view_nxt.hex_from_fourth = state_r.hex_from_fourth &&
                               ((state_r.pos != POS_LATER) || is_hex(char_i));
  end

  always_comb begin
    state_nxt = state_r;
    if (step_i) begin
      if (last_i) begin
        state_nxt = TOK_INIT;
      end else begin
        state_nxt = view_nxt;
        if (state_r.pos != POS_LATER) state_nxt.pos = state_r.pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TOK_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign view_o = view_nxt;

endmodule

`default_nettype wire

// ===== rtl/atc_classify.sv =====
// ----------------------------------------------------------------------------
// atc_classify
// Priority class decode of a closed token.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_classify (
  input  wire atc_pkg::tok_view_t view_i,
  input  wire [7:0]               char_i,   // last character of the token
  output atc_pkg::cls_t           cls_o
);
  import atc_pkg::*;

  logic [CHAR_W-1:0] f;
  logic [CHAR_W-1:0] s;
  logic              hex_prefix;
  logic              is_reg;

  assign f = view_i.first_byte;
  assign s = view_i.second_byte;
  assign hex_prefix = (view_i.pos >= POS_THIRD) && (s == CH_ZERO) && view_i.third_is_x;
  assign is_reg = ((view_i.pos == POS_SECOND) &&
                   (((f == CH_P) && (s == CH_C)) || ((f == CH_S) && (s == CH_P)))) ||
                  ((f == CH_R) && view_i.decimal_from_second);

  always_comb begin
    if ((f == CH_AT) && (char_i == CH_COLON))                 cls_o = CLS_LABELDEF;
    else if (f == CH_DOT)                                     cls_o = CLS_DIRECTIVE;
    else if (view_i.all_letters)                              cls_o = CLS_INSTR;
    else if (is_reg)                                          cls_o = CLS_REG;
    else if ((f == CH_HASH) && (hex_prefix ? view_i.hex_from_fourth
                                           : view_i.decimal_from_second))
                                                              cls_o = CLS_IMM;
    else if ((view_i.pos == POS_LATER) && (f == CH_DOLLAR) && hex_prefix &&
             view_i.hex_from_fourth)                          cls_o = CLS_ADDR;
    else if (f == CH_AT)                                      cls_o = CLS_LABELREF;
    else if ((f == CH_COMMA) && (view_i.pos == POS_FIRST))    cls_o = CLS_COMMA;
    else if ((f == CH_QUOTE) && (char_i == CH_QUOTE))         cls_o = CLS_STRING;
    else if ((f == CH_NL) && (view_i.pos == POS_FIRST))       cls_o = CLS_EOL;
    else                                                      cls_o = CLS_UNKNOWN;
  end

endmodule

`default_nettype wire
